/* rtl/rpy_pkg.sv */
package rpy_pkg;

    localparam int FRAC      = 30;
    localparam int TABLE_LEN = 30;
    localparam int DW        = 34;   // CORDIC datapath width, Q1.30 plus guard
    localparam int ZW        = 34;   // angle datapath width

    localparam logic signed [DW-1:0] GAIN_Q30    = 34'sd652032874;
    localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;

    // atan(2^-i) in Q.30
    function automatic logic signed [ZW-1:0] atan_q30(input int idx);
        logic signed [ZW-1:0] v;
        begin
            v = '0;
            unique case (idx)
                0:  v = 34'sd843314856;
                1:  v = 34'sd497837829;
                2:  v = 34'sd263043836;
                3:  v = 34'sd133525158;
                4:  v = 34'sd67021686;
                5:  v = 34'sd33543515;
                6:  v = 34'sd16775850;
                7:  v = 34'sd8388437;
                8:  v = 34'sd4194282;
                9:  v = 34'sd2097149;
                10: v = 34'sd1048575;
                11: v = 34'sd524287;
                12: v = 34'sd262143;
                13: v = 34'sd131071;
                14: v = 34'sd65535;
                15: v = 34'sd32767;
                16: v = 34'sd16383;
                17: v = 34'sd8191;
                18: v = 34'sd4095;
                19: v = 34'sd2047;
                20: v = 34'sd1023;
                21: v = 34'sd511;
                22: v = 34'sd255;
                23: v = 34'sd127;
                24: v = 34'sd63;
                25: v = 34'sd31;
                26: v = 34'sd15;
                27: v = 34'sd7;
                28: v = 34'sd3;
                29: v = 34'sd1;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

    // one CORDIC lane's data as it moves from cell to cell
    typedef struct packed {
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 neg;
    } t_lane;

endpackage

/* rtl/roll_pitch_yaw_rotation_matrix.sv */
// Roll-pitch-yaw to rotation matrix, R = Rz(yaw) * Ry(pitch) * Rx(roll).
// Input beat: roll, pitch, yaw as signed Q2.(ANGLE_WIDTH-3) radians.
// Output beat: the nine entries m11..m33, signed Q1.(ENTRY_WIDTH-2), saturated to +-1.
// Both channels are valid/ready. The block is one pipeline of NS + 3 register
// stages, NS being CORDIC_STAGES capped at TABLE_LEN (30): one input stage with
// quadrant fold, NS cells that each do one micro-rotation on all three angles, and
// two multiply levels, the second of which is the output register.
// One beat is taken every cycle while the output is free or being drained.
// When the receiver stalls with a beat on the output, the whole pipe holds and ready
// drops in that same cycle, whether or not earlier stages are empty.
// Reset clears the valid bits of all stages; payload registers are not cleared.
module roll_pitch_yaw_rotation_matrix #(
    parameter int ANGLE_WIDTH   = 16,
    parameter int ENTRY_WIDTH   = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  logic signed [ANGLE_WIDTH-1:0] i_roll,
    input  logic signed [ANGLE_WIDTH-1:0] i_pitch,
    input  logic signed [ANGLE_WIDTH-1:0] i_yaw,
    output logic o_valid,
    input  logic i_ready,
    output logic signed [ENTRY_WIDTH-1:0] o_m11,
    output logic signed [ENTRY_WIDTH-1:0] o_m12,
    output logic signed [ENTRY_WIDTH-1:0] o_m13,
    output logic signed [ENTRY_WIDTH-1:0] o_m21,
    output logic signed [ENTRY_WIDTH-1:0] o_m22,
    output logic signed [ENTRY_WIDTH-1:0] o_m23,
    output logic signed [ENTRY_WIDTH-1:0] o_m31,
    output logic signed [ENTRY_WIDTH-1:0] o_m32,
    output logic signed [ENTRY_WIDTH-1:0] o_m33
);
    import rpy_pkg::*;

    localparam int NS    = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
    localparam int DEPTH = NS + 3;
    localparam int ASH   = FRAC - (ANGLE_WIDTH - 3);

    // valid bit per stage; stage DEPTH-1 is the output register
    logic [DEPTH-1:0] r_vld;
    logic en;

    // the pipe moves unless the output holds a beat that is not taken
    assign en      = !(r_vld[DEPTH-1] && !i_ready);
    assign o_ready = en;
    assign o_valid = r_vld[DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_valid};
        end
    end

    // input stage: scale to Q.30 and fold into +-pi/2
    function automatic t_lane fold(input logic signed [ANGLE_WIDTH-1:0] a);
        t_lane l;
        logic signed [ZW+ANGLE_WIDTH-1:0] w;
        logic signed [ZW-1:0] z;
        begin
            w = (ZW+ANGLE_WIDTH)'(a);
            w = w <<< ASH;
            z = w[ZW-1:0];
            l.x = GAIN_Q30;
            l.y = '0;
            l.neg = 1'b0;
            if (z > HALF_PI_Q30) begin
                z = z - PI_Q30;
                l.neg = 1'b1;
            end else if (z < -HALF_PI_Q30) begin
                z = z + PI_Q30;
                l.neg = 1'b1;
            end
            l.z = z;
            return l;
        end
    endfunction

    t_lane [2:0] lane [NS+1];
    t_lane [2:0] r_in;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in[0] <= fold(i_roll);
            r_in[1] <= fold(i_pitch);
            r_in[2] <= fold(i_yaw);
        end
    end
    assign lane[0] = r_in;

    // chain of CORDIC cells
    for (genvar g = 0; g < NS; g++) begin : g_cell
        rpy_cell #(.SHIFT(g)) u_cell (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_lane (lane[g]),
            .o_lane (lane[g+1])
        );
    end

    logic [9*ENTRY_WIDTH-1:0] ent;
    rpy_mat #(.ENTRY_WIDTH(ENTRY_WIDTH)) u_mat (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_lane (lane[NS]),
        .o_ent  (ent)
    );

    assign o_m11 = ent[0*ENTRY_WIDTH +: ENTRY_WIDTH];
    assign o_m12 = ent[1*ENTRY_WIDTH +: ENTRY_WIDTH];
    assign o_m13 = ent[2*ENTRY_WIDTH +: ENTRY_WIDTH];
    assign o_m21 = ent[3*ENTRY_WIDTH +: ENTRY_WIDTH];
    assign o_m22 = ent[4*ENTRY_WIDTH +: ENTRY_WIDTH];
    assign o_m23 = ent[5*ENTRY_WIDTH +: ENTRY_WIDTH];
    assign o_m31 = ent[6*ENTRY_WIDTH +: ENTRY_WIDTH];
    assign o_m32 = ent[7*ENTRY_WIDTH +: ENTRY_WIDTH];
    assign o_m33 = ent[8*ENTRY_WIDTH +: ENTRY_WIDTH];
endmodule

/* rtl/rpy_cell.sv */
// One CORDIC micro-rotation for the three angle lanes.
module rpy_cell #(
    parameter int SHIFT = 0
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  rpy_pkg::t_lane [2:0] i_lane,
    output rpy_pkg::t_lane [2:0] o_lane
);
    import rpy_pkg::*;

    t_lane [2:0] n_lane;
    t_lane [2:0] r_lane;

    // rotate each lane toward zero residual angle
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_lane[k].neg = i_lane[k].neg;
            if (!i_lane[k].z[ZW-1]) begin
                n_lane[k].x = i_lane[k].x - (i_lane[k].y >>> SHIFT);
                n_lane[k].y = i_lane[k].y + (i_lane[k].x >>> SHIFT);
                n_lane[k].z = i_lane[k].z - atan_q30(SHIFT);
            end else begin
                n_lane[k].x = i_lane[k].x + (i_lane[k].y >>> SHIFT);
                n_lane[k].y = i_lane[k].y - (i_lane[k].x >>> SHIFT);
                n_lane[k].z = i_lane[k].z + atan_q30(SHIFT);
            end
        end
    end

    // advance when the pipe moves
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;
endmodule

/* rtl/rpy_mat.sv */
// Matrix products from sine and cosine: two registered multiply levels and output rounding.
module rpy_mat #(
    parameter int ENTRY_WIDTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  rpy_pkg::t_lane [2:0]        i_lane,
    output logic [9*ENTRY_WIDTH-1:0]    o_ent
);
    import rpy_pkg::*;

    localparam int G  = ENTRY_WIDTH - 2;
    localparam int SH = FRAC - G;

    typedef logic signed [DW-1:0] t_q;

    function automatic t_q qmul(input t_q a, input t_q b);
        logic signed [2*DW-1:0] p;
        begin
            p = a * b;
            return t_q'(p >>> FRAC);
        end
    endfunction

    function automatic logic [ENTRY_WIDTH-1:0] to_entry(input t_q v);
        logic signed [DW:0] r;
        logic signed [DW:0] one;
        begin
            one = (DW+1)'(1) <<< G;
            if (SH > 0) begin
                r = ((DW+1)'(v) + ((DW+1)'(1) <<< (SH > 0 ? SH - 1 : 0))) >>> SH;
            end else begin
                r = (DW+1)'(v);
            end
            if (r > one) r = one;
            if (r < -one) r = -one;
            return r[ENTRY_WIDTH-1:0];
        end
    endfunction

    t_q cr, sr, cp, sp, cy, sy;
    always_comb begin
        cr = i_lane[0].neg ? -i_lane[0].x : i_lane[0].x;
        sr = i_lane[0].neg ? -i_lane[0].y : i_lane[0].y;
        cp = i_lane[1].neg ? -i_lane[1].x : i_lane[1].x;
        sp = i_lane[1].neg ? -i_lane[1].y : i_lane[1].y;
        cy = i_lane[2].neg ? -i_lane[2].x : i_lane[2].x;
        sy = i_lane[2].neg ? -i_lane[2].y : i_lane[2].y;
    end

    // level 1: sign fix registered; pairwise products
    t_q r_cr, r_sr, r_sp;
    t_q r_spcy, r_spsy, r_cpcy, r_cpsy, r_srcp, r_crcp, r_crsy, r_srsy, r_crcy, r_srcy;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cr <= cr; r_sr <= sr; r_sp <= sp;
            r_spcy <= qmul(sp, cy); r_spsy <= qmul(sp, sy);
            r_cpcy <= qmul(cp, cy); r_cpsy <= qmul(cp, sy);
            r_srcp <= qmul(sr, cp); r_crcp <= qmul(cr, cp);
            r_crsy <= qmul(cr, sy); r_srsy <= qmul(sr, sy);
            r_crcy <= qmul(cr, cy); r_srcy <= qmul(sr, cy);
        end
    end

    // level 2: triple products, combine, round and saturate
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_ent[0*ENTRY_WIDTH +: ENTRY_WIDTH] <= to_entry(r_cpcy);
            o_ent[1*ENTRY_WIDTH +: ENTRY_WIDTH] <= to_entry(qmul(r_sr, r_spcy) - r_crsy);
            o_ent[2*ENTRY_WIDTH +: ENTRY_WIDTH] <= to_entry(qmul(r_cr, r_spcy) + r_srsy);
            o_ent[3*ENTRY_WIDTH +: ENTRY_WIDTH] <= to_entry(r_cpsy);
            o_ent[4*ENTRY_WIDTH +: ENTRY_WIDTH] <= to_entry(qmul(r_sr, r_spsy) + r_crcy);
            o_ent[5*ENTRY_WIDTH +: ENTRY_WIDTH] <= to_entry(qmul(r_cr, r_spsy) - r_srcy);
            o_ent[6*ENTRY_WIDTH +: ENTRY_WIDTH] <= to_entry(-r_sp);
            o_ent[7*ENTRY_WIDTH +: ENTRY_WIDTH] <= to_entry(r_srcp);
            o_ent[8*ENTRY_WIDTH +: ENTRY_WIDTH] <= to_entry(r_crcp);
        end
    end
endmodule
